// ===== hdl/scfr_pkg.sv =====
// Shared definitions for the serial command frame receiver:
// action codes, speed codes, register indexes, reset values and the end-around add. No dependencies.
`timescale 1ns / 1ps

package scfr_pkg;

  localparam int unsigned FrameDataBytesDefault = 4;

  // Input action codes
  localparam logic [1:0] ACT_START   = 2'd0;
  localparam logic [1:0] ACT_BYTE    = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  // Speed mode codes
  localparam logic [1:0] SPEED_STANDARD = 2'd0;
  localparam logic [1:0] SPEED_HIGH     = 2'd1;
  localparam logic [1:0] SPEED_ULTRA    = 2'd2;

  // Configuration register indexes
  localparam logic REG_ERROR_THRESHOLD = 1'b0;
  localparam logic REG_USE_ULTRA_HIGH  = 1'b1;

  localparam logic [7:0] ErrorThresholdReset = 8'd2;

  // One's complement style add: carry out of bit 7 folds back into bit 0.
  function automatic logic [7:0] add_end_around(input logic [7:0] sum, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, sum} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

endpackage

// ===== hdl/serial_command_frame_receiver.sv =====
// Top level of the serial command frame receiver: byte collection, checksum,
// error counter with speed fallback, and the result register. Uses scfr_pkg.
`timescale 1ns / 1ps

// How to use this block
// - Input channel (in_valid_i / in_ready_o) carries one item per handshake:
//   an action (start frame, byte received, command line released) and a byte.
// - Output channel (out_valid_o / out_ready_i) carries one item per closed
//   frame: checksum verdict, device, command, aux word, speed mode and a flag
//   that marks a speed toggle caused by this frame.
// - Each input item is handled in the cycle it is accepted; the result for a
//   checksum byte is visible on the output in the cycle after acceptance.
// - Throughput is one item per cycle. The single result register sets it:
//   in_ready_o is high whenever that register is empty or being drained.
// - When the receiver stalls (out_ready_i low with a result pending), the
//   result holds and input items wait until it is taken.
// - Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at
//   the next edge; write them only while the block is idle.
// - Reset clears the frame state, the error counter, the speed mode
//   (standard), the threshold (2) and the ultra-high select; no result pends.
module serial_command_frame_receiver #(
  parameter int unsigned FrameDataBytes = scfr_pkg::FrameDataBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [7:0] cfg_wdata_i,
  // input items
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] action_i,
  input  logic [7:0] data_byte_i,
  // result items
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_valid_o,
  output logic [7:0]  dev_addr_o,
  output logic [7:0]  command_code_o,
  output logic [15:0] aux_value_o,
  output logic [1:0]  link_rate_o,
  output logic        speed_changed_o
);
  import scfr_pkg::*;

  // Keep at least four slots so the fixed result fields always have a place
  localparam int unsigned StoreDepth = (FrameDataBytes > 4) ? FrameDataBytes : 4;
  localparam int unsigned IdxW       = $clog2(StoreDepth);
  localparam int unsigned CntW       = $clog2(FrameDataBytes + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(FrameDataBytes);

  // Configuration registers
  logic [7:0] threshold_q;
  logic       use_ultra_q;

  // Frame state
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            collecting_q, collecting_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      bad_cnt_q, bad_cnt_d;
  logic [1:0]      speed_q, speed_d;
  logic [7:0]      fields_q [StoreDepth];

  // Result register
  logic        out_valid_q;
  logic        frame_valid_q;
  logic [7:0]  dev_addr_q, command_code_q;
  logic [15:0] aux_value_q;
  logic [1:0]  link_rate_q;
  logic        speed_changed_q;

  logic       in_fire;
  logic       byte_in_frame;
  logic       store_byte;
  logic       close_frame;
  logic       chk_ok;
  logic       toggle;
  logic [7:0] bad_inc;
  logic [7:0] fld [4];

  assign in_ready_o    = !out_valid_q || out_ready_i;
  assign in_fire       = in_valid_i && in_ready_o;
  assign byte_in_frame = in_fire && (action_i == ACT_BYTE) && collecting_q;
  assign store_byte    = byte_in_frame && (cnt_q < LastCnt);
  assign close_frame   = byte_in_frame && (cnt_q == LastCnt);
  assign chk_ok        = (data_byte_i == sum_q);
  assign bad_inc       = bad_cnt_q + 8'd1;
  // Toggle only on an exact match, so the counter may wrap past the threshold
  assign toggle        = close_frame && !chk_ok && (bad_inc == threshold_q);

  // Fields past the configured frame length read as zero
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      fld[k] = (k < FrameDataBytes) ? fields_q[k] : 8'd0;
    end
  end

  always_comb begin
    cnt_d        = cnt_q;
    collecting_d = collecting_q;
    sum_d        = sum_q;
    bad_cnt_d    = bad_cnt_q;
    speed_d      = speed_q;
    if (in_fire) begin
      case (action_i)
        ACT_START: begin
          collecting_d = 1'b1;
          cnt_d        = '0;
          sum_d        = 8'd0;
        end
        ACT_RELEASE: begin
          collecting_d = 1'b0;
          cnt_d        = '0;
        end
        ACT_BYTE: begin
          if (store_byte) begin
            sum_d = add_end_around(sum_q, data_byte_i);
            cnt_d = cnt_q + CntW'(1);
          end else if (close_frame) begin
            collecting_d = 1'b0;
            cnt_d        = '0;
            if (!chk_ok) begin
              bad_cnt_d = toggle ? 8'd0 : bad_inc;
            end
            if (toggle) begin
              speed_d = (speed_q != SPEED_STANDARD) ? SPEED_STANDARD :
                        (use_ultra_q ? SPEED_ULTRA : SPEED_HIGH);
            end
          end
        end
        default: begin
          // unused action code: drop
        end
      endcase
    end
  end

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q  <= ErrorThresholdReset;
      use_ultra_q  <= 1'b0;
      cnt_q        <= '0;
      collecting_q <= 1'b0;
      sum_q        <= 8'd0;
      bad_cnt_q    <= 8'd0;
      speed_q      <= SPEED_STANDARD;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ERROR_THRESHOLD: threshold_q <= cfg_wdata_i;
          REG_USE_ULTRA_HIGH:  use_ultra_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      cnt_q        <= cnt_d;
      collecting_q <= collecting_d;
      sum_q        <= sum_d;
      bad_cnt_q    <= bad_cnt_d;
      speed_q      <= speed_d;
      if (close_frame) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: frame byte store and result fields, no reset needed
  always_ff @(posedge clk_i) begin
    if (store_byte) begin
      fields_q[IdxW'(cnt_q)] <= data_byte_i;
    end
    if (close_frame) begin
      frame_valid_q   <= chk_ok;
      dev_addr_q      <= fld[0];
      command_code_q  <= fld[1];
      aux_value_q     <= {fld[3], fld[2]};
      link_rate_q     <= speed_d;
      speed_changed_q <= toggle;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_valid_o   = frame_valid_q;
  assign dev_addr_o      = dev_addr_q;
  assign command_code_o  = command_code_q;
  assign aux_value_o     = aux_value_q;
  assign link_rate_o     = link_rate_q;
  assign speed_changed_o = speed_changed_q;

  // A speed toggle can only come from a failed checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && speed_changed_o) |-> !frame_valid_o)
    else $error("speed toggle reported on a good frame");

  // The byte counter never runs past the checksum slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LastCnt)
    else $error("byte counter beyond frame length");

  // Outside a frame the counter rests at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !collecting_q |-> (cnt_q == '0))
    else $error("byte counter nonzero while idle");

  // A toggle clears the error counter and reports the new speed
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    toggle |=> (bad_cnt_q == 8'd0) && (link_rate_o == speed_q) && speed_changed_o)
    else $error("toggle did not clear counter or report speed");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for serial_command_frame_receiver: a frame scoreboard class
// predicts each result from the accepted input items, and plain tasks drive both channels.
// Depends on hdl/scfr_pkg.sv and hdl/serial_command_frame_receiver.sv.
`timescale 1ns / 1ps

module tb;
  import scfr_pkg::*;

  localparam int unsigned FrameBytes   = FrameDataBytesDefault;
  localparam int          SettleCycles = 4;
  localparam int          CycleLimit   = 200000;

  // Scoreboard: tracks the frame state of the block from the accepted input items,
  // queues the expected result for every checksum byte and checks each result.
  class frame_scoreboard;
    typedef struct packed {
      logic        frame_valid;
      logic [7:0]  dev_addr;
      logic [7:0]  command_code;
      logic [15:0] aux_value;
      logic [1:0]  link_rate;
      logic        speed_changed;
    } frame_result_t;

    frame_result_t expected_frames[$];

    // register copies
    logic [7:0] threshold = ErrorThresholdReset;
    logic       ultra_sel = 1'b0;

    // frame state
    bit         collecting;
    int         byte_count;
    logic [7:0] checksum_acc;
    logic [7:0] frame_bytes[4];
    logic [7:0] bad_count = 8'd0;
    logic [1:0] speed = SPEED_STANDARD;

    int mismatches;
    int items_used;
    int frames_checked;
    int bad_frames;
    int toggles;

    // Add one byte and fold the carry out of bit 7 back into bit 0.
    static function logic [7:0] fold_add(logic [7:0] acc, logic [7:0] b);
      logic [8:0] wide;
      wide = {1'b0, acc} + {1'b0, b};
      return wide[7:0] + {7'd0, wide[8]};
    endfunction

    function logic [7:0] field(int idx);
      return (idx < FrameBytes) ? frame_bytes[idx] : 8'd0;
    endfunction

    function void set_register(logic idx, logic [7:0] value);
      if (idx == REG_ERROR_THRESHOLD) threshold = value;
      else ultra_sel = value[0];
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    // Advance the frame state by one accepted item; queue a result on the checksum byte.
    function void note_item(logic [1:0] act, logic [7:0] b);
      frame_result_t r;
      case (act)
        ACT_START: begin
          collecting   = 1'b1;
          byte_count   = 0;
          checksum_acc = 8'd0;
          items_used++;
        end
        ACT_RELEASE: begin
          collecting = 1'b0;
          byte_count = 0;
          items_used++;
        end
        ACT_BYTE: begin
          if (collecting) begin
            items_used++;
            if (byte_count < FrameBytes) begin
              if (byte_count < 4) frame_bytes[byte_count] = b;
              checksum_acc = fold_add(checksum_acc, b);
              byte_count++;
            end else begin
              r.frame_valid   = (b == checksum_acc);
              r.speed_changed = 1'b0;
              if (!r.frame_valid) begin
                bad_count++;
                if (bad_count == threshold) begin
                  bad_count = 8'd0;
                  speed = (speed == SPEED_STANDARD) ?
                          (ultra_sel ? SPEED_ULTRA : SPEED_HIGH) : SPEED_STANDARD;
                  r.speed_changed = 1'b1;
                end
              end
              collecting     = 1'b0;
              byte_count     = 0;
              r.dev_addr     = field(0);
              r.command_code = field(1);
              r.aux_value    = {field(3), field(2)};
              r.link_rate    = speed;
              expected_frames.push_back(r);
            end
          end
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation, field by field.
    task check_result(logic fv, logic [7:0] dev, logic [7:0] cmd, logic [15:0] aux,
                      logic [1:0] spd, logic chg);
      frame_result_t e;
      if (expected_frames.size() == 0) begin
        report("result arrived with no frame expected");
        return;
      end
      e = expected_frames.pop_front();
      frames_checked++;
      if (!e.frame_valid) bad_frames++;
      if (e.speed_changed) toggles++;
      if (fv !== e.frame_valid)
        report($sformatf("frame_valid got %0b want %0b", fv, e.frame_valid));
      if (dev !== e.dev_addr)
        report($sformatf("dev_addr got %02h want %02h", dev, e.dev_addr));
      if (cmd !== e.command_code)
        report($sformatf("command_code got %02h want %02h", cmd, e.command_code));
      if (aux !== e.aux_value)
        report($sformatf("aux_value got %04h want %04h", aux, e.aux_value));
      if (spd !== e.link_rate)
        report($sformatf("link_rate got %0d want %0d", spd, e.link_rate));
      if (chg !== e.speed_changed)
        report($sformatf("speed_changed got %0b want %0b", chg, e.speed_changed));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = REG_ERROR_THRESHOLD;
  logic [7:0]  cfg_wdata = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  action = ACT_RELEASE;
  logic [7:0]  data_byte = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        frame_valid;
  logic [7:0]  dev_addr;
  logic [7:0]  command_code;
  logic [15:0] aux_value;
  logic [1:0]  link_rate;
  logic        speed_changed;

  int sender_idle_pct = 6;
  int recv_idle_pct   = 67;
  int cycle_count;
  int settings_used;

  frame_scoreboard sb = new();

  serial_command_frame_receiver i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .action_i       (action),
    .data_byte_i    (data_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .frame_valid_o  (frame_valid),
    .dev_addr_o     (dev_addr),
    .command_code_o (command_code),
    .aux_value_o    (aux_value),
    .link_rate_o    (link_rate),
    .speed_changed_o(speed_changed)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hold the receiver back at random; a single assignment per edge.
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Observe both handshakes with the values that were settled before the edge.
  // Check first: a result can never belong to the item accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_result(frame_valid, dev_addr, command_code, aux_value, link_rate,
                        speed_changed);
      if (in_valid && in_ready) sb.note_item(action, data_byte);
    end
  end

  // Watchdog: give up on a hung handshake.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               sb.pending());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offer one item and hold it until accepted. Valid is dropped only when a gap is taken,
  // so back-to-back items keep valid high without a glitch.
  task automatic send_item(logic [1:0] act, logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid  <= 1'b1;
    action    <= act;
    data_byte <= b;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Stop sending, wait for every expected result, then let the block settle.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write both registers back to back while the block is idle.
  task automatic write_config(logic [7:0] thr, logic ultra);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ERROR_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk_i);
    sb.set_register(REG_ERROR_THRESHOLD, thr);
    cfg_index <= REG_USE_ULTRA_HIGH;
    cfg_wdata <= {7'd0, ultra};
    @(posedge clk_i);
    sb.set_register(REG_USE_ULTRA_HIGH, {7'd0, ultra});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Send the data bytes and the checksum byte of an already opened frame.
  task automatic send_frame_body(logic [7:0] d0, logic [7:0] d1, logic [7:0] d2,
                                 logic [7:0] d3, logic [7:0] ck);
    send_item(ACT_BYTE, d0);
    send_item(ACT_BYTE, d1);
    send_item(ACT_BYTE, d2);
    send_item(ACT_BYTE, d3);
    send_item(ACT_BYTE, ck);
  endtask

  function automatic logic [7:0] pick_byte();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hff;
    return 8'($urandom);
  endfunction

  // Mostly well-formed frames with random content; some are cut short, restarted,
  // padded with unused action codes or followed by stray bytes.
  task automatic send_random_frame();
    logic [7:0] d[4];
    logic [7:0] sum;
    int         shape;
    int         cut;
    sum   = 8'd0;
    shape = $urandom_range(99);
    for (int i = 0; i < 4; i++) begin
      d[i] = pick_byte();
      sum  = frame_scoreboard::fold_add(sum, d[i]);
    end
    send_item(ACT_START, 8'($urandom));
    if (shape < 8) begin
      // restart mid-frame: the partial bytes are discarded
      repeat ($urandom_range(1, 3)) send_item(ACT_BYTE, 8'($urandom));
      send_item(ACT_START, 8'($urandom));
    end
    cut = (shape >= 8 && shape < 16) ? $urandom_range(0, 3) : 4;
    for (int i = 0; i < 4; i++) begin
      if (i == cut) begin
        // command line released before the checksum: no result
        send_item(ACT_RELEASE, 8'($urandom));
        return;
      end
      if ($urandom_range(19) == 0) send_item(ACT_UNUSED, 8'($urandom));
      send_item(ACT_BYTE, d[i]);
    end
    send_item(ACT_BYTE, ($urandom_range(99) < 55) ? sum : 8'($urandom));
    if ($urandom_range(9) == 0) send_item(ACT_BYTE, 8'($urandom));
    if ($urandom_range(3) == 0) send_item(ACT_RELEASE, 8'($urandom));
  endtask

  task automatic run_random(int goal);
    while (sb.items_used < goal) begin
      if ($urandom_range(99) < 80) send_random_frame();
      else send_item(2'($urandom_range(3)), 8'($urandom));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed part, reset register values (threshold 2, high as alternate mode).
    send_item(ACT_BYTE, 8'h5a);        // byte outside a frame: dropped
    send_item(ACT_UNUSED, 8'ha5);      // unused action code: no effect
    send_item(ACT_RELEASE, 8'h00);     // release while idle
    send_item(ACT_START, 8'h00);       // all ones: sum stays 0xff, good frame
    send_frame_body(8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
    send_item(ACT_BYTE, 8'h12);        // byte after the checksum: dropped
    send_item(ACT_START, 8'hff);       // all zero with a wrong checksum: first error
    send_frame_body(8'h00, 8'h00, 8'h00, 8'h00, 8'h01);
    send_item(ACT_START, 8'h00);       // partial frame, then restart
    send_item(ACT_BYTE, 8'h80);
    send_item(ACT_BYTE, 8'h80);
    send_item(ACT_START, 8'h00);       // carries folded back: sum 0x03, second error toggles
    send_frame_body(8'h80, 8'h80, 8'hfe, 8'h03, 8'h00);
    send_item(ACT_START, 8'h00);       // released before the checksum
    send_item(ACT_BYTE, 8'h11);
    send_item(ACT_UNUSED, 8'h77);
    send_item(ACT_BYTE, 8'h22);
    send_item(ACT_RELEASE, 8'h00);
    send_item(ACT_BYTE, 8'h33);        // dropped after release
    wait_drained();

    // Random phases: lowest threshold with ultra, highest threshold, then a middle value.
    write_config(8'd1, 1'b1);
    run_random(sb.items_used + 230);
    wait_drained();

    sender_idle_pct = 67;
    recv_idle_pct   = 6;
    write_config(8'd255, 1'b0);
    run_random(sb.items_used + 230);
    wait_drained();

    sender_idle_pct = 0;
    recv_idle_pct   = 0;
    write_config(8'($urandom_range(2, 4)), 1'b1);
    run_random(sb.items_used + 230);
    wait_drained();

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("run covered %0d effective items and %0d register settings", sb.items_used,
             settings_used);
    $display("checked %0d frames: %0d with bad checksum, %0d speed toggles",
             sb.frames_checked, sb.bad_frames, sb.toggles);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
